/* hw/rtl/timed_dedup_table_assert.svh */
// Assertion macros used by the dedup table RTL.
`ifndef TIMED_DEDUP_TABLE_ASSERT_SVH
`define TIMED_DEDUP_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define TDT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TDT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);
`else
`define TDT_ASSERT(lbl, clk, rstn, prop, msg)
`define TDT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

/* hw/rtl/tdt_pkg.sv */
// Package: types and constants of the dedup table.
`default_nettype none
package tdt_pkg;

  localparam int MAC_W  = 48;
  localparam int CLS_W  = 2;
  localparam int TIME_W = 32;

  localparam logic [TIME_W-1:0] DEFAULT_COOLDOWN_MS = 32'd5000;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [CLS_W-1:0]  cls;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/tdt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module tdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hw/rtl/timed_dedup_table.sv */
// Top level: cooldown-based dedup table for device-address detection events.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one event transaction: a 48-bit
//    device address, a 2-bit class and a 32-bit millisecond timestamp.
//  - Output channel (out_valid/out_ready) returns one transaction per event:
//    out_suppressed is 1 when the event hits a stored entry within cooldown.
//  - cfg_wr_en/cfg_wr_data write the cooldown in ms; 0 selects 5000 ms.
//    Write only while the block is idle.
//  - One event is worked on at a time. The table sits in one RAM, scanned one
//    entry per cycle through its single read port; the scan stops at the
//    first match on a hit and after the last filled entry on a miss. The next
//    event is taken once the result is loaded into the output register.
//  - A finished result waits in the output register; a new event is accepted
//    while it waits. If the receiver still stalls when the next result is
//    ready, the block holds it and takes no new event until the slot frees.
//  - Reset clears fill count, replace head, cooldown and the output valid;
//    the RAM contents are not cleared, only filled entries are ever read.
`default_nettype none
module timed_dedup_table
  import tdt_pkg::*;
#(
  parameter int TABLE_DEPTH = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // config
  input  wire logic              cfg_wr_en,
  input  wire logic [TIME_W-1:0] cfg_wr_data,
  // event in
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [MAC_W-1:0]  in_mac_address,
  input  wire logic [CLS_W-1:0]  in_event_class,
  input  wire logic [TIME_W-1:0] in_now_ms,
  // result out
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_suppressed
);

  localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(TABLE_DEPTH);
  localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(TABLE_DEPTH - 1);

  state_t state_r, state_nxt;

  logic [TIME_W-1:0] cooldown_r;
  logic [CNTW-1:0]   fill_count_r, fill_count_nxt;
  logic [IDXW-1:0]   replace_head_r, replace_head_nxt;

  // latched event
  logic [MAC_W-1:0]  ev_mac_r;
  logic [CLS_W-1:0]  ev_cls_r;
  logic [TIME_W-1:0] ev_now_r;

  // scan pipeline
  logic [CNTW-1:0]   scan_idx_r, scan_idx_nxt;
  logic              rd_valid_r, rd_valid_nxt;
  logic [IDXW-1:0]   rd_idx_r;
  logic              sup_r, sup_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_sup_r;
  logic              out_load;

  // RAM side
  logic              ram_we;
  logic [IDXW-1:0]   ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic              issue;
  logic              hit;
  logic [TIME_W-1:0] cd_eff;
  logic [TIME_W-1:0] age;
  logic              in_fire;

  assign in_fire = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign cd_eff = (cooldown_r == '0) ? DEFAULT_COOLDOWN_MS : cooldown_r;
  assign age    = ev_now_r - ram_rdata.stamp;  // wraps mod 2^32

  // one read per cycle while entries remain below the fill count
  assign issue  = (state_r == ST_SCAN) && (scan_idx_r < fill_count_r);
  assign ram_re = issue;
  assign hit    = (state_r == ST_SCAN) && rd_valid_r &&
                  (ram_rdata.mac == ev_mac_r) && (ram_rdata.cls == ev_cls_r);

  // result register loads when free or being drained this cycle
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt        = state_r;
    fill_count_nxt   = fill_count_r;
    replace_head_nxt = replace_head_r;
    scan_idx_nxt     = scan_idx_r;
    rd_valid_nxt     = 1'b0;
    sup_nxt          = sup_r;
    ram_we           = 1'b0;
    ram_waddr        = rd_idx_r;
    ram_wdata        = '{mac: ev_mac_r, cls: ev_cls_r, stamp: ev_now_r};
    out_valid_nxt    = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          scan_idx_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // first match in index order decides
          if (age < cd_eff) begin
            sup_nxt = 1'b1;
          end else begin
            sup_nxt = 1'b0;
            ram_we  = 1'b1;  // refresh timestamp
          end
          state_nxt = ST_DONE;
        end else if (!issue && !rd_valid_r) begin
          // miss: fill next free slot, else overwrite at head
          sup_nxt = 1'b0;
          ram_we  = 1'b1;
          if (fill_count_r < DEPTH_CNT) begin
            ram_waddr      = fill_count_r[IDXW-1:0];
            fill_count_nxt = fill_count_r + CNTW'(1);
          end else begin
            ram_waddr        = replace_head_r;
            replace_head_nxt = (replace_head_r == LAST_IDX) ? '0
                                                            : replace_head_r + IDXW'(1);
          end
          state_nxt = ST_DONE;
        end else begin
          rd_valid_nxt = issue;
          if (issue) begin
            scan_idx_nxt = scan_idx_r + CNTW'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cooldown_r     <= '0;
      fill_count_r   <= '0;
      replace_head_r <= '0;
      rd_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      fill_count_r   <= fill_count_nxt;
      replace_head_r <= replace_head_nxt;
      rd_valid_r     <= rd_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_wr_en) begin
        cooldown_r <= cfg_wr_data;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= scan_idx_r[IDXW-1:0];
    sup_r      <= sup_nxt;
    if (in_fire) begin
      ev_mac_r <= in_mac_address;
      ev_cls_r <= in_event_class;
      ev_now_r <= in_now_ms;
    end
    if (out_load) begin
      out_sup_r <= sup_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_suppressed = out_sup_r;

  tdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx_r[IDXW-1:0]),
    .rdata (ram_rdata_raw)
  );

`include "timed_dedup_table_assert.svh"

  `TDT_ASSERT(a_fill_bound, clk, rst_n, fill_count_r <= DEPTH_CNT,
              "fill count above depth")
  `TDT_ASSERT(a_head_moves_when_full, clk, rst_n,
              (replace_head_nxt != replace_head_r) |-> (fill_count_r == DEPTH_CNT),
              "head moved before table full")
  `TDT_ASSERT(a_write_in_scan, clk, rst_n, ram_we |-> (state_r == ST_SCAN),
              "table write outside scan")
  `TDT_ASSERT(a_write_in_filled, clk, rst_n,
              ram_we |-> (CNTW'(ram_waddr) < fill_count_nxt),
              "write beyond filled region")
  `TDT_ASSERT_NEXT(a_hit_ends_scan, clk, rst_n, hit, (state_r == ST_DONE),
                   "scan continued past match")

endmodule
`default_nettype wire

/* sim/timed_dedup_table_check.sv */
`timescale 1ns / 100ps
// Checker for timed_dedup_table: predicts each event's verdict and compares with results.
module timed_dedup_table_check
  import tdt_pkg::*;
#(
  parameter int TABLE_DEPTH = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [MAC_W-1:0]  in_mac_address,
  input  logic [CLS_W-1:0]  in_event_class,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_suppressed,
  output int                mismatch_count,
  output int                results_owed
);

  entry_t            cache [TABLE_DEPTH];
  int unsigned       fill_count;
  int unsigned       replace_head;
  logic [TIME_W-1:0] cooldown_reg;
  logic              suppress_q [$];

  // Lowest-index hit decides; a miss fills the next free slot, then round-robin.
  function automatic logic predict_suppressed(input logic [MAC_W-1:0]  mac,
                                              input logic [CLS_W-1:0]  cls,
                                              input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] window;
    logic [TIME_W-1:0] age;
    int unsigned       slot;
    window = (cooldown_reg == '0) ? DEFAULT_COOLDOWN_MS : cooldown_reg;
    for (int unsigned i = 0; i < fill_count; i++) begin
      if (cache[i].mac == mac && cache[i].cls == cls) begin
        age = now - cache[i].stamp;
        if (age < window) return 1'b1;
        cache[i].stamp = now;
        return 1'b0;
      end
    end
    if (fill_count < TABLE_DEPTH) begin
      slot = fill_count;
      fill_count++;
    end else begin
      slot = replace_head;
      replace_head = (replace_head + 1) % TABLE_DEPTH;
    end
    cache[slot].mac   = mac;
    cache[slot].cls   = cls;
    cache[slot].stamp = now;
    return 1'b0;
  endfunction

  always @(posedge clk) begin : monitor
    logic want;
    if (!rst_n) begin
      fill_count     = 0;
      replace_head   = 0;
      cooldown_reg   = '0;
      mismatch_count = 0;
      suppress_q.delete();
    end else begin
      // results first, so a result never pairs with an event taken on the same edge
      if (out_valid && out_ready) begin
        if (suppress_q.size() == 0) begin
          $error("out_suppressed: expected no transaction, actual %0b", out_suppressed);
          mismatch_count++;
        end else begin
          want = suppress_q.pop_front();
          if (out_suppressed !== want) begin
            $error("out_suppressed: expected %0b, actual %0b", want, out_suppressed);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        suppress_q.push_back(predict_suppressed(in_mac_address, in_event_class, in_now_ms));
      if (cfg_wr_en)
        cooldown_reg = cfg_wr_data;
    end
    results_owed = suppress_q.size();
  end

endmodule

/* sim/timed_dedup_table_test.sv */
`timescale 1ns / 100ps
// Testbench top for timed_dedup_table: stimulus, idling and verdict.
module timed_dedup_table_test;
  import tdt_pkg::*;

  localparam int TABLE_DEPTH     = 48;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int POOL_MAX        = 100;
  // Worst-case scan plus write, with margin; used as the settle time when idle.
  localparam int SETTLE_CYCLES   = TABLE_DEPTH + 8;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [TIME_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [MAC_W-1:0]  in_mac_address;
  logic [CLS_W-1:0]  in_event_class;
  logic [TIME_W-1:0] in_now_ms;
  logic              out_valid;
  logic              out_ready;
  logic              out_suppressed;

  int                mismatch_count;
  int                results_owed;

  // Effective cooldown as the stimulus sees it, to aim timestamps at the window edge.
  logic [TIME_W-1:0] cd_eff = DEFAULT_COOLDOWN_MS;
  // When set, neither side idles: back-to-back transactions on both channels.
  bit                steady_flow;

  // Key pool for one phase. Keys come back again and again so that hits,
  // refreshes and (with large pools) round-robin replacement all happen.
  logic [MAC_W-1:0]  pool_mac   [POOL_MAX];
  logic [CLS_W-1:0]  pool_cls   [POOL_MAX];
  logic [TIME_W-1:0] pool_stamp [POOL_MAX];

  timed_dedup_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mac_address(in_mac_address),
    .in_event_class(in_event_class),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_suppressed(out_suppressed)
  );

  timed_dedup_table_check #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mac_address(in_mac_address),
    .in_event_class(in_event_class),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_suppressed(out_suppressed),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: the slowest legal run is far below this.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Idle length: mostly none, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: ready drops for random stretches unless the phase runs steady.
  initial begin : receiver
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!steady_flow && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len() + 1) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // One event transaction; returns on the falling edge after acceptance,
  // after an optional sender gap.
  task automatic send_event(input logic [MAC_W-1:0]  mac,
                            input logic [CLS_W-1:0]  cls,
                            input logic [TIME_W-1:0] now);
    int unsigned gap;
    in_valid       <= 1'b1;
    in_mac_address <= mac;
    in_event_class <= cls;
    in_now_ms      <= now;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (!steady_flow) begin
      gap = idle_len();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Cooldown is only changed with the block idle.
  task automatic write_cooldown(input logic [TIME_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cd_eff = (value == '0) ? DEFAULT_COOLDOWN_MS : value;
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] phase_cd   [PHASES];
    int unsigned       phase_pool [PHASES];
    logic [TIME_W-1:0] delta;
    int unsigned       pool_n;
    int unsigned       k;
    int unsigned       r;

    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_mac_address = '0;
    in_event_class = '0;
    in_now_ms      = '0;

    // Phase plan: both register extremes, the default, and a few windows in between.
    phase_cd   = '{32'd0, 32'd100, 32'd1, 32'hFFFF_FFFF, 32'd5000, 32'd0, 32'd0};
    phase_cd[5] = $urandom_range(5001, 200000);
    // Pool sizes below and above the table depth, including one on each side of it.
    phase_pool = '{6, 40, 60, 100, 20, 47, 49};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part, default 5000 ms window after reset ----
    send_event(48'h0, 2'd0, 32'd0);                          // miss on empty table
    send_event(48'h0, 2'd0, 32'd4999);                       // one below window: suppressed
    send_event(48'h0, 2'd0, 32'd5000);                       // exactly window: passes, refresh
    send_event(48'h0, 2'd1, 32'd5000);                       // same address, other class: miss
    send_event(48'hFFFF_FFFF_FFFF, 2'd3, 32'hFFFF_FFFF);     // all-ones fields
    send_event(48'hFFFF_FFFF_FFFF, 2'd3, 32'd0);             // timestamp wrapped forward by 1
    send_event(48'hFFFF_FFFF_FFFF, 2'd3, 32'hFFFF_FF00);     // time went back: huge age, passes
    send_event(48'h0, 2'd0, 32'd5000);                       // zero age: suppressed
    send_event(48'hAAAA_AAAA_AAAA, 2'd2, 32'h5555_5555);
    send_event(48'h5555_5555_5555, 2'd1, 32'hAAAA_AAAA);
    send_event(48'hAAAA_AAAA_AAAA, 2'd2, 32'h5555_5555 + 32'd4999);

    // smallest nonzero window: only an identical timestamp is suppressed
    write_cooldown(32'd1);
    send_event(48'h0, 2'd0, 32'd5000);
    send_event(48'h0, 2'd0, 32'd5001);

    // largest window: everything but an age of all ones is suppressed
    write_cooldown(32'hFFFF_FFFF);
    send_event(48'h0, 2'd0, 32'd5000);                       // age wraps to all ones: passes
    send_event(48'h0, 2'd0, 32'd0);

    // ---- random part ----
    for (int p = 0; p < PHASES; p++) begin
      write_cooldown(phase_cd[p]);
      steady_flow = (p % 3 == 1);
      pool_n = phase_pool[p];

      // Some keys are near copies of their neighbor (one address bit off, or
      // the same address in the next class) to stress the compare.
      for (int i = 0; i < pool_n; i++) begin
        r = $urandom_range(0, 9);
        if (i > 0 && r < 2) begin
          pool_mac[i] = pool_mac[i-1] ^ (48'd1 << $urandom_range(0, MAC_W - 1));
          pool_cls[i] = pool_cls[i-1];
        end else if (i > 0 && r < 4) begin
          pool_mac[i] = pool_mac[i-1];
          pool_cls[i] = pool_cls[i-1] + 2'd1;
        end else begin
          pool_mac[i] = MAC_W'({$urandom, $urandom});
          pool_cls[i] = CLS_W'($urandom_range(0, 3));
        end
        pool_stamp[i] = $urandom;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 5) begin
          // noise: a key that is almost surely new, at any time
          send_event(MAC_W'({$urandom, $urandom}), CLS_W'($urandom_range(0, 3)), $urandom);
        end else begin
          // Timestamps advance per key, aimed around the window edge, with
          // occasional big jumps and steps back in time.
          k = $urandom_range(0, pool_n - 1);
          r = $urandom_range(0, 99);
          if (r < 10)      delta = '0;
          else if (r < 25) delta = $urandom_range(1, 20);
          else if (r < 45) delta = $urandom_range(0, cd_eff - 1);
          else if (r < 58) delta = cd_eff - 1;
          else if (r < 71) delta = cd_eff;
          else if (r < 78) delta = cd_eff + 1;
          else if (r < 90) delta = $urandom;
          else             delta = 32'd0 - $urandom_range(1, 1000);
          pool_stamp[k] = pool_stamp[k] + delta;
          send_event(pool_mac[k], pool_cls[k], pool_stamp[k]);
        end
        if ($urandom_range(0, 199) == 0)
          drain_results();
      end
    end

    // ---- wind down ----
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tdt_pkg.sv
hw/rtl/tdt_ram.sv
hw/rtl/timed_dedup_table.sv
sim/timed_dedup_table_check.sv
sim/timed_dedup_table_test.sv
